>>> hdl/gms_pkg.sv
package gms_pkg;

  // Grid limits and derived widths
  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 32;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W     = $clog2(CELLS + 1);
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RDIM_W    = $clog2(MAX_ROWS + 1);
  localparam int CDIM_W    = $clog2(MAX_COLS + 1);
  localparam int DIM_EXT_W = 9;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 10;
  localparam int DIV_W     = $clog2(CNT_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     DIM_RESET = CFG_W'(32);

  // Cell store codes
  localparam logic [CNT_W-1:0] WALL_MARK  = '1;
  localparam logic [CNT_W-1:0] START_MARK = CNT_W'(1);

  // Neighbor order: above, left, below, right
  localparam logic [1:0] NB_ABOVE = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_BELOW = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  typedef enum logic {OP_LOAD, OP_READ} op_e;
  typedef enum logic [1:0] {KIND_OPEN, KIND_WALL, KIND_START, KIND_EXIT} kind_e;
  typedef enum logic [1:0] {DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT} dir_e;
  typedef enum logic {RES_SUMMARY, RES_MOVE} res_e;
  typedef enum logic [1:0] {SEL_SCAN, SEL_QUEUE, SEL_NB, SEL_EXIT} csel_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_SR_INIT, ST_SC_RD, ST_SC_CHK, ST_POP_CHK, ST_POP_RD,
    ST_POP_GET, ST_POP_DIST, ST_NB_RD, ST_NB_CHK, ST_BT_INIT, ST_BT_CUR,
    ST_BT_NB, ST_BT_CHK, ST_SUM, ST_MOVE
  } state_e;

  typedef struct packed {
    op_e   opcode;
    kind_e cell_kind;
  } in_t;

  typedef struct packed {
    res_e              result_kind;
    logic              reachable;
    logic [STEP_W-1:0] step_count;
    dir_e              move_dir;
    logic              last_move;
    logic              exhausted;
  } out_t;

  typedef struct packed {
    logic  ld_write;
    logic  rd_start;
    logic  div_init;
    logic  div_step;
    logic  sr_init;
    logic  sc_check;
    logic  pop_issue;
    logic  pop_get;
    logic  pop_dist;
    logic  nb_next;
    logic  nb_check;
    logic  bt_init;
    logic  bt_cur;
    logic  bt_step;
    logic  sum_done;
    logic  out_sum;
    logic  out_move;
    csel_e cell_sel;
  } cmd_t;

  typedef struct packed {
    logic load_exit;
    logic load_last;
    logic div_last;
    logic search_due;
    logic scan_more;
    logic q_nonempty;
    logic nb_ok;
    logic nb_last;
    logic exit_ok;
    logic cur_ok;
    logic cur_gt1;
    logic bt_match;
    logic bt_more;
  } sts_t;

  // Forward move that leads from the chosen neighbor back to the current cell
  function automatic dir_e bt_dir(logic [1:0] nb);
    dir_e d;
    unique case (nb)
      NB_ABOVE: d = DIR_DOWN;
      NB_LEFT:  d = DIR_RIGHT;
      NB_BELOW: d = DIR_UP;
      NB_RIGHT: d = DIR_LEFT;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/gms_ctrl.sv
module gms_ctrl import gms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  item_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.cell_sel = SEL_SCAN;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (item_i.opcode == OP_LOAD) begin
            cmd_o.ld_write = 1'b1;
            if (sts_i.load_exit) begin
              cmd_o.div_init = 1'b1;
              state_d = ST_DIV;
            end else if (sts_i.load_last) begin
              state_d = ST_SR_INIT;
            end
          end else begin
            cmd_o.rd_start = 1'b1;
            state_d = ST_MOVE;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = sts_i.search_due ? ST_SR_INIT : ST_IDLE;
        end
      end
      ST_SR_INIT: begin
        cmd_o.sr_init = 1'b1;
        state_d = ST_SC_RD;
      end
      // start cell scan: each cell is read, then checked
      ST_SC_RD: begin
        state_d = sts_i.scan_more ? ST_SC_CHK : ST_POP_CHK;
      end
      ST_SC_CHK: begin
        cmd_o.sc_check = 1'b1;
        state_d = ST_SC_RD;
      end
      // wavefront expansion
      ST_POP_CHK: begin
        state_d = sts_i.q_nonempty ? ST_POP_RD : ST_BT_INIT;
      end
      ST_POP_RD: begin
        cmd_o.pop_issue = 1'b1;
        state_d = ST_POP_GET;
      end
      ST_POP_GET: begin
        cmd_o.cell_sel = SEL_QUEUE;
        cmd_o.pop_get  = 1'b1;
        state_d = ST_POP_DIST;
      end
      ST_POP_DIST: begin
        cmd_o.pop_dist = 1'b1;
        state_d = ST_NB_RD;
      end
      ST_NB_RD: begin
        cmd_o.cell_sel = SEL_NB;
        if (sts_i.nb_ok) begin
          state_d = ST_NB_CHK;
        end else if (sts_i.nb_last) begin
          state_d = ST_POP_CHK;
        end else begin
          cmd_o.nb_next = 1'b1;
        end
      end
      ST_NB_CHK: begin
        cmd_o.cell_sel = SEL_NB;
        cmd_o.nb_check = 1'b1;
        if (sts_i.nb_last) begin
          state_d = ST_POP_CHK;
        end else begin
          cmd_o.nb_next = 1'b1;
          state_d = ST_NB_RD;
        end
      end
      // backtrack from the exit
      ST_BT_INIT: begin
        cmd_o.cell_sel = SEL_EXIT;
        if (sts_i.exit_ok) begin
          cmd_o.bt_init = 1'b1;
          state_d = ST_BT_CUR;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_BT_CUR: begin
        if (sts_i.cur_ok && sts_i.cur_gt1) begin
          cmd_o.bt_cur = 1'b1;
          state_d = ST_BT_NB;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_BT_NB: begin
        cmd_o.cell_sel = SEL_NB;
        if (sts_i.nb_ok) begin
          state_d = ST_BT_CHK;
        end else if (sts_i.nb_last) begin
          state_d = ST_SUM;
        end else begin
          cmd_o.nb_next = 1'b1;
        end
      end
      ST_BT_CHK: begin
        cmd_o.cell_sel = SEL_NB;
        if (sts_i.bt_match) begin
          cmd_o.bt_step = 1'b1;
          state_d = sts_i.bt_more ? ST_BT_NB : ST_SUM;
        end else if (sts_i.nb_last) begin
          state_d = ST_SUM;
        end else begin
          cmd_o.nb_next = 1'b1;
          state_d = ST_BT_NB;
        end
      end
      ST_SUM: begin
        cmd_o.out_sum  = 1'b1;
        cmd_o.sum_done = 1'b1;
        state_d = ST_IDLE;
      end
      ST_MOVE: begin
        cmd_o.out_move = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/gms_dpath.sv
module gms_dpath import gms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_t                  item_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 res_valid_o,
  output out_t                 res_o
);

  localparam int QW = ROW_W + COL_W;

  // Configuration and state
  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [CNT_W-1:0]  load_cnt_q, path_len_q, rd_ptr_q;
  logic [ROW_W-1:0]  exit_row_q;
  logic [COL_W-1:0]  exit_col_q;
  logic              exit_seen_q;
  // Divider for the exit coordinates
  logic [CNT_W-1:0]  dvd_q, quo_q, quo_n;
  logic [CDIM_W-1:0] rem_q, rem_n;
  logic [CDIM_W:0]   rem_sh, rem_sub;
  logic [DIV_W-1:0]  div_cnt_q;
  logic              div_ge;
  // Search
  logic [CNT_W-1:0]  head_q, tail_q, scan_i_q, dist_q, cur_val_q, steps_q;
  logic [ROW_W-1:0]  scan_r_q, cur_r_q, nr, sel_r;
  logic [COL_W-1:0]  scan_c_q, cur_c_q, nc, sel_c;
  logic [1:0]        nb_q;
  logic              nb_ok;
  logic              hit_q, last_q;

  // Memories
  logic [CNT_W-1:0]  cell_mem [CELLS];
  logic [QW-1:0]     q_mem    [CELLS];
  logic [1:0]        path_mem [CELLS];
  logic [CNT_W-1:0]  cell_rd_q;
  logic [QW-1:0]     q_rd_q;
  logic [1:0]        path_rd_q;

  logic [IDX_W-1:0]  cell_raddr, cell_waddr, path_waddr;
  logic [CNT_W-1:0]  cell_wdata, load_val;
  logic              cell_we, q_we, cell_zero, load_in_range;
  logic [QW-1:0]     q_wdata;

  // Effective grid size
  logic [DIM_EXT_W-1:0] rows_x, cols_x;
  logic [RDIM_W-1:0]    eff_rows;
  logic [CDIM_W-1:0]    eff_cols;
  logic [CNT_W-1:0]     total;

  always_comb begin
    rows_x = DIM_EXT_W'(rows_q);
    cols_x = DIM_EXT_W'(cols_q);
    if (rows_x == '0) begin
      rows_x = DIM_EXT_W'(1);
    end else if (rows_x > DIM_EXT_W'(MAX_ROWS)) begin
      rows_x = DIM_EXT_W'(MAX_ROWS);
    end
    if (cols_x == '0) begin
      cols_x = DIM_EXT_W'(1);
    end else if (cols_x > DIM_EXT_W'(MAX_COLS)) begin
      cols_x = DIM_EXT_W'(MAX_COLS);
    end
  end

  assign eff_rows = rows_x[RDIM_W-1:0];
  assign eff_cols = cols_x[CDIM_W-1:0];
  assign total    = CNT_W'(CNT_W'(eff_rows) * CNT_W'(eff_cols));

  function automatic logic [IDX_W-1:0] cell_idx(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                                logic [CDIM_W-1:0] w);
    logic [CNT_W-1:0] p;
    p = CNT_W'(CNT_W'(r) * CNT_W'(w)) + CNT_W'(c);
    return p[IDX_W-1:0];
  endfunction

  // Neighbor of the current cell
  always_comb begin
    nr = cur_r_q;
    nc = cur_c_q;
    unique case (nb_q)
      NB_ABOVE: begin
        nr    = cur_r_q - ROW_W'(1);
        nb_ok = (cur_r_q != '0);
      end
      NB_LEFT: begin
        nc    = cur_c_q - COL_W'(1);
        nb_ok = (cur_c_q != '0);
      end
      NB_BELOW: begin
        nr    = cur_r_q + ROW_W'(1);
        nb_ok = ((RDIM_W'(cur_r_q) + RDIM_W'(1)) < eff_rows);
      end
      NB_RIGHT: begin
        nc    = cur_c_q + COL_W'(1);
        nb_ok = ((CDIM_W'(cur_c_q) + CDIM_W'(1)) < eff_cols);
      end
    endcase
  end

  // Cell read address source
  always_comb begin
    unique case (cmd_i.cell_sel)
      SEL_SCAN: begin
        sel_r = scan_r_q;
        sel_c = scan_c_q;
      end
      SEL_QUEUE: begin
        sel_r = q_rd_q[QW-1:COL_W];
        sel_c = q_rd_q[COL_W-1:0];
      end
      SEL_NB: begin
        sel_r = nr;
        sel_c = nc;
      end
      SEL_EXIT: begin
        sel_r = exit_row_q;
        sel_c = exit_col_q;
      end
    endcase
  end

  assign cell_raddr = cell_idx(sel_r, sel_c, eff_cols);

  // Load value for a cell kind
  always_comb begin
    unique case (item_i.cell_kind)
      KIND_OPEN:  load_val = '0;
      KIND_WALL:  load_val = WALL_MARK;
      KIND_START: load_val = START_MARK;
      KIND_EXIT:  load_val = '0;
    endcase
  end

  assign load_in_range = (load_cnt_q < total);
  assign cell_zero     = (cell_rd_q == '0);
  assign cell_we    = (cmd_i.ld_write && load_in_range) || (cmd_i.nb_check && cell_zero);
  assign cell_waddr = cmd_i.ld_write ? load_cnt_q[IDX_W-1:0] : cell_raddr;
  assign cell_wdata = cmd_i.ld_write ? load_val : dist_q;
  assign q_we       = (cmd_i.sc_check && (cell_rd_q == START_MARK)) ||
                      (cmd_i.nb_check && cell_zero);
  assign q_wdata    = cmd_i.sc_check ? {scan_r_q, scan_c_q} : {nr, nc};
  assign path_waddr = IDX_W'(cur_val_q - CNT_W'(2));

  // Cell store
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd_q <= cell_mem[cell_raddr];
  end

  // Wavefront queue
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[tail_q[IDX_W-1:0]] <= q_wdata;
    end
    q_rd_q <= q_mem[head_q[IDX_W-1:0]];
  end

  // Path store
  always_ff @(posedge clk_i) begin
    if (cmd_i.bt_step) begin
      path_mem[path_waddr] <= bt_dir(nb_q);
    end
    path_rd_q <= path_mem[rd_ptr_q[IDX_W-1:0]];
  end

  // Restoring divide step: raster index over column count
  assign rem_sh  = {rem_q, dvd_q[CNT_W-1]};
  assign div_ge  = (rem_sh >= (CDIM_W+1)'(eff_cols));
  assign rem_sub = rem_sh - (CDIM_W+1)'(eff_cols);
  assign rem_n   = div_ge ? rem_sub[CDIM_W-1:0] : rem_sh[CDIM_W-1:0];
  assign quo_n   = {quo_q[CNT_W-2:0], div_ge};

  // Control and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= DIM_RESET;
      cols_q      <= DIM_RESET;
      load_cnt_q  <= '0;
      exit_row_q  <= '0;
      exit_col_q  <= '0;
      exit_seen_q <= 1'b0;
      path_len_q  <= '0;
      rd_ptr_q    <= '0;
      div_cnt_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      scan_i_q    <= '0;
      scan_r_q    <= '0;
      scan_c_q    <= '0;
      nb_q        <= '0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ROWS) begin
          rows_q <= cfg_data_i;
        end else if (cfg_index_i == REG_COLS) begin
          cols_q <= cfg_data_i;
        end
      end
      if (cmd_i.ld_write) begin
        load_cnt_q <= load_cnt_q + CNT_W'(1);
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_W'(1);
        if (sts_o.div_last) begin
          exit_row_q  <= quo_n[ROW_W-1:0];
          exit_col_q  <= rem_n[COL_W-1:0];
          exit_seen_q <= 1'b1;
        end
      end
      if (cmd_i.sr_init) begin
        path_len_q <= '0;
        rd_ptr_q   <= '0;
        head_q     <= '0;
        tail_q     <= '0;
        scan_i_q   <= '0;
        scan_r_q   <= '0;
        scan_c_q   <= '0;
      end
      // raster walk of the start scan
      if (cmd_i.sc_check) begin
        scan_i_q <= scan_i_q + CNT_W'(1);
        if ((CDIM_W'(scan_c_q) + CDIM_W'(1)) == eff_cols) begin
          scan_c_q <= '0;
          scan_r_q <= scan_r_q + ROW_W'(1);
        end else begin
          scan_c_q <= scan_c_q + COL_W'(1);
        end
      end
      if (q_we) begin
        tail_q <= tail_q + CNT_W'(1);
      end
      if (cmd_i.pop_issue) begin
        head_q <= head_q + CNT_W'(1);
      end
      if (cmd_i.pop_dist || cmd_i.bt_cur || cmd_i.bt_step) begin
        nb_q <= '0;
      end else if (cmd_i.nb_next) begin
        nb_q <= nb_q + 2'd1;
      end
      if (cmd_i.bt_step && (cur_val_q == CNT_W'(2))) begin
        path_len_q <= steps_q;
      end
      if (cmd_i.sum_done) begin
        load_cnt_q  <= '0;
        exit_seen_q <= 1'b0;
      end
      // path read
      if (cmd_i.rd_start) begin
        hit_q  <= (rd_ptr_q < path_len_q);
        last_q <= ((rd_ptr_q + CNT_W'(1)) == path_len_q);
        if (rd_ptr_q < path_len_q) begin
          rd_ptr_q <= rd_ptr_q + CNT_W'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q <= load_cnt_q;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
    if (cmd_i.pop_get) begin
      cur_r_q <= q_rd_q[QW-1:COL_W];
      cur_c_q <= q_rd_q[COL_W-1:0];
    end else if (cmd_i.bt_init) begin
      cur_r_q <= exit_row_q;
      cur_c_q <= exit_col_q;
    end else if (cmd_i.bt_step) begin
      cur_r_q <= nr;
      cur_c_q <= nc;
    end
    if (cmd_i.pop_dist) begin
      dist_q <= cell_rd_q + CNT_W'(1);
    end
    if (cmd_i.bt_cur) begin
      cur_val_q <= cell_rd_q;
      steps_q   <= cell_rd_q - CNT_W'(1);
    end else if (cmd_i.bt_step) begin
      cur_val_q <= cur_val_q - CNT_W'(1);
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.load_exit  = load_in_range && (item_i.cell_kind == KIND_EXIT);
    sts_o.load_last  = ((load_cnt_q + CNT_W'(1)) >= total);
    sts_o.div_last   = (div_cnt_q == DIV_W'(CNT_W - 1));
    sts_o.search_due = (load_cnt_q >= total);
    sts_o.scan_more  = (scan_i_q < total);
    sts_o.q_nonempty = (head_q != tail_q);
    sts_o.nb_ok      = nb_ok;
    sts_o.nb_last    = (nb_q == NB_RIGHT);
    sts_o.exit_ok    = exit_seen_q && (RDIM_W'(exit_row_q) < eff_rows) &&
                       (CDIM_W'(exit_col_q) < eff_cols);
    sts_o.cur_ok     = !cell_zero && (cell_rd_q != WALL_MARK);
    sts_o.cur_gt1    = (cell_rd_q > CNT_W'(1));
    sts_o.bt_match   = (cell_rd_q == (cur_val_q - CNT_W'(1)));
    sts_o.bt_more    = (cur_val_q > CNT_W'(2));
  end

  // Result item
  assign res_valid_o = cmd_i.out_sum || cmd_i.out_move;

  always_comb begin
    res_o = '0;
    res_o.result_kind = RES_SUMMARY;
    res_o.move_dir    = DIR_UP;
    if (cmd_i.out_sum) begin
      res_o.reachable  = (path_len_q != '0);
      res_o.step_count = path_len_q[STEP_W-1:0];
    end else if (cmd_i.out_move) begin
      res_o.result_kind = RES_MOVE;
      res_o.move_dir    = hit_q ? dir_e'(path_rd_q) : DIR_UP;
      res_o.last_move   = hit_q && last_q;
      res_o.exhausted   = !hit_q;
    end
  end

endmodule

>>> hdl/grid_maze_shortest_path.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+-------------------------------------
// command   | start, busy (start & !busy)  | item_i : in_t (opcode, cell_kind)
// result    | result_valid_o, one cycle    | result_o : out_t
// config    | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A load item needs no further states; a load of an exit cell adds
// bit-serial division for its row and column. A read item gives its move
// in the cycle after acceptance, through the path store read port.
// The last load starts the search: a start scan over every cell, then
// wavefront expansion and a backtrack from the exit, bound by the single
// cell store read port. busy stays high until the summary is out.
// Reset clears all control state; the stores are not cleared.
// Results cannot be stalled: each one is valid for exactly one cycle.
module grid_maze_shortest_path import gms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  item_i,
  output logic                 result_valid_o,
  output out_t                 result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .item_i (item_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  gms_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

>>> dv/tb_grid_maze_shortest_path.sv
module tb_grid_maze_shortest_path;
  timeunit 1ns;
  timeprecision 1ps;

  import gms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned ITEM_GOAL   = 1850;
  localparam int unsigned WALL_CODE   = 32'hFFFF_FFFF;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  item_i = '0;
  logic                 result_valid_o;
  out_t                 result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  grid_maze_shortest_path u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Maze predictor state
  int unsigned dist_map [CELLS];
  dir_e        route [CELLS];
  int unsigned route_len, walk_ptr;
  int unsigned cells_loaded, goal_row, goal_col;
  bit          goal_seen;
  int unsigned rows_reg = 32, cols_reg = 32;

  out_t        pending_results[$];
  int unsigned errors, items_sent, cycles, mazes_solved, paths_found, moves_seen;
  bit          quiet;

  function automatic int unsigned rows_used();
    if (rows_reg < 1) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned cols_used();
    if (cols_reg < 1) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function automatic void label_cell(int unsigned idx, int unsigned d,
                                     ref int unsigned wave[$]);
    if (dist_map[idx] == 0) begin
      dist_map[idx] = d;
      wave.push_back(idx);
    end
  endfunction

  // Wavefront from all starts, then backtrack from the exit; returns step count
  function automatic int unsigned solve_maze();
    int unsigned rows, cols, total, idx, r, c, nd, cur, want, steps;
    int unsigned wave[$];
    dir_e d;
    bit hit;
    rows = rows_used();
    cols = cols_used();
    total = rows * cols;
    route_len = 0;
    walk_ptr = 0;
    for (int unsigned i = 0; i < total; i++)
      if (dist_map[i] == 1) wave.push_back(i);
    while (wave.size() != 0) begin
      idx = wave.pop_front();
      r = idx / cols;
      c = idx % cols;
      nd = dist_map[idx] + 1;
      if (r > 0) label_cell(idx - cols, nd, wave);
      if (c > 0) label_cell(idx - 1, nd, wave);
      if (r + 1 < rows) label_cell(idx + cols, nd, wave);
      if (c + 1 < cols) label_cell(idx + 1, nd, wave);
    end
    if (!goal_seen || goal_row >= rows || goal_col >= cols) return 0;
    r = goal_row;
    c = goal_col;
    cur = dist_map[r * cols + c];
    if (cur == 0 || cur == WALL_CODE) return 0;
    steps = cur - 1;
    while (cur > 1) begin
      want = cur - 1;
      hit = 1'b1;
      if (r > 0 && dist_map[(r - 1) * cols + c] == want) begin
        d = DIR_DOWN; r--;
      end else if (c > 0 && dist_map[r * cols + c - 1] == want) begin
        d = DIR_RIGHT; c--;
      end else if (r + 1 < rows && dist_map[(r + 1) * cols + c] == want) begin
        d = DIR_UP; r++;
      end else if (c + 1 < cols && dist_map[r * cols + c + 1] == want) begin
        d = DIR_LEFT; c++;
      end else begin
        hit = 1'b0;
      end
      if (!hit) return 0;
      route[(cur - 2) % CELLS] = d;
      cur--;
    end
    route_len = steps;
    return steps;
  endfunction

  // Expected result of one accepted item
  task automatic predict(in_t it);
    out_t r;
    int unsigned total, steps;
    r = '0;
    total = rows_used() * cols_used();
    if (it.opcode == OP_LOAD) begin
      if (cells_loaded < total) begin
        case (it.cell_kind)
          KIND_WALL:  dist_map[cells_loaded] = WALL_CODE;
          KIND_START: dist_map[cells_loaded] = 1;
          KIND_EXIT: begin
            dist_map[cells_loaded] = 0;
            goal_row = cells_loaded / cols_used();
            goal_col = cells_loaded % cols_used();
            goal_seen = 1'b1;
          end
          default:    dist_map[cells_loaded] = 0;
        endcase
      end
      cells_loaded++;
      if (cells_loaded >= total) begin
        steps = solve_maze();
        cells_loaded = 0;
        goal_seen = 1'b0;
        r.result_kind = RES_SUMMARY;
        r.reachable = (steps > 0);
        r.step_count = STEP_W'(steps);
        pending_results.push_back(r);
        mazes_solved++;
        if (steps > 0) paths_found++;
      end
    end else begin
      r.result_kind = RES_MOVE;
      if (walk_ptr < route_len) begin
        r.move_dir = route[walk_ptr % CELLS];
        r.last_move = (walk_ptr + 1 == route_len);
        walk_ptr++;
        moves_seen++;
      end else begin
        r.exhausted = 1'b1;
      end
      pending_results.push_back(r);
    end
  endtask

  // Result checker
  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h", $time, result_o);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.result_kind, result_o.result_kind);
        check_field("reachable", want.reachable, result_o.reachable);
        check_field("step_count", want.step_count, result_o.step_count);
        check_field("move_dir", want.move_dir, result_o.move_dir);
        check_field("last_move", want.last_move, result_o.last_move);
        check_field("exhausted", want.exhausted, result_o.exhausted);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one item; returns in the step of its acceptance edge
  task automatic send_item(op_e op, kind_e kind);
    in_t it;
    it.opcode = op;
    it.cell_kind = kind;
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict(it);
    items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Drain all results and let any search or division finish
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_ROWS) rows_reg = val & 6'h3F;
    else if (idx == REG_COLS) cols_reg = val & 6'h3F;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_dims(int unsigned rows, int unsigned cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  // Load cells from text: '.' open, '#' wall, 'S' start, 'T' exit
  task automatic load_text(string s);
    kind_e k;
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        "#": k = KIND_WALL;
        "S": k = KIND_START;
        "T": k = KIND_EXIT;
        default: k = KIND_OPEN;
      endcase
      send_item(OP_LOAD, k);
    end
  endtask

  task automatic read_moves(int unsigned n);
    repeat (n) send_item(OP_READ, kind_e'($urandom_range(0, 3)));
  endtask

  task automatic read_path(int unsigned extra);
    read_moves(route_len - walk_ptr + extra);
  endtask

  // One maze in the current size; clean mazes have one start and, on more than one cell, one exit
  task automatic random_maze(bit clean);
    int unsigned total, s, e, wall_pct;
    kind_e k;
    total = rows_used() * cols_used();
    s = $urandom_range(0, total - 1);
    e = $urandom_range(0, total - 1);
    if (total > 1) while (e == s) e = $urandom_range(0, total - 1);
    wall_pct = $urandom_range(0, 40);
    for (int unsigned i = 0; i < total; i++) begin
      if (!clean) k = kind_e'($urandom_range(0, 3));
      else if (i == s) k = KIND_START;
      else if (i == e) k = KIND_EXIT;
      else if ($urandom_range(0, 99) < wall_pct) k = KIND_WALL;
      else k = KIND_OPEN;
      if ($urandom_range(0, 30) == 0) send_item(OP_READ, KIND_OPEN);
      send_item(OP_LOAD, k);
    end
    read_path($urandom_range(0, 2));
  endtask

  // Reads before any search run off an empty path
  task automatic test_read_empty();
    read_moves(3);
  endtask

  // Full 32 by 32 maze at reset size; also fills every cell entry once
  task automatic test_full_grid();
    random_maze(1'b1);
  endtask

  // Directed corner cases on a 3 by 3 grid
  task automatic test_special_cases();
    set_dims(3, 3);
    load_text("S........T"); // ten loads: the tenth starts a new maze
    load_text("........");   // finish that maze: exit with no start
    settle();
    load_text("S.......T");  // tie order on an open grid
    read_path(1);
    load_text("S.S.#...T");  // several starts
    read_path(1);
    load_text("S.T.#...T");  // several exits, the last one counts
    read_path(0);
    load_text("S.......#");  // no exit
    read_path(1);
    load_text("....#...T");  // no start
    read_path(1);
    load_text("S#.##...T");  // walled in
    read_path(1);
    load_text("ST.......");  // one step
    read_path(2);
  endtask

  // Register extremes: zero acts as one, large values clamp
  task automatic test_clamps();
    set_dims(0, 0);
    load_text("S");
    load_text("T");
    read_path(1);
    set_dims(63, 1);
    random_maze(1'b1);
    set_dims(1, 45);
    random_maze(1'b1);
    set_dims(2, 63);
    random_maze(1'b1);
    set_dims(32, 32);
  endtask

  // Size changes part way through a maze
  task automatic test_resize_midload();
    set_dims(4, 4);
    load_text("S........T");
    write_reg(REG_ROWS, 2);  // exit row now outside the grid
    load_text(".");
    read_path(1);
    set_dims(4, 4);
    load_text("S...#");
    write_reg(REG_COLS, 3);
    load_text("......T");
    read_path(1);
  endtask

  // Random mazes, mostly small, a few tall or wide
  task automatic test_random_mazes();
    int unsigned pick, r, c;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL - 250) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      // no size changes or drains in the gap-free tail
      if (quiet) pick = 9;
      if (pick < 3) begin
        r = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 8);
        c = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 63) : $urandom_range(1, 8);
        if (r > 8 && c > 8) c = $urandom_range(1, 3);
        set_dims(r, c);
      end else if (pick == 3) begin
        settle();  // let every expected result come back before sending on
      end
      random_maze($urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_read_empty();
    test_full_grid();
    test_special_cases();
    test_clamps();
    test_resize_midload();
    test_random_mazes();
    settle();
    repeat (50) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Covered %0d items: %0d mazes solved, %0d with a path, %0d path moves read",
             items_sent, mazes_solved, paths_found, moves_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/gms_pkg.sv
hdl/gms_ctrl.sv
hdl/gms_dpath.sv
hdl/grid_maze_shortest_path.sv
dv/tb_grid_maze_shortest_path.sv
